### hdl/aes128_pkg.sv
// Shared types, constants and round functions for the AES-128 encryption pipeline.
package aes128_pkg;

    // Cipher geometry
    localparam int ROUND_COUNT = 10;
    localparam int STORE_DEPTH = 2 * (ROUND_COUNT + 1);
    localparam int SLOT_W      = 5;
    localparam int BLOCK_W     = 128;
    localparam int WORD_W      = 64;

    localparam logic [SLOT_W-1:0] STORE_DEPTH_SLOT = SLOT_W'(STORE_DEPTH);

    // Item opcodes
    localparam logic OP_LOAD_KEY = 1'b0;
    localparam logic OP_ENCRYPT  = 1'b1;

    // GF(2^8) reduction constant
    localparam logic [7:0] GF_POLY = 8'h1b;

    typedef struct packed {
        logic              opcode;
        logic [SLOT_W-1:0] key_slot;
        logic [WORD_W-1:0] key_word;
        logic [WORD_W-1:0] plain_high;
        logic [WORD_W-1:0] plain_low;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] cipher_high;
        logic [WORD_W-1:0] cipher_low;
    } out_item_t;

    // One pipeline stage: valid flag and cipher state
    typedef struct packed {
        logic               valid;
        logic [BLOCK_W-1:0] data;
    } stage_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // Multiply by x in GF(2^8)
    function automatic logic [7:0] gf_double(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
    endfunction

    // One cipher round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
    // Byte i of the state sits at bits [127-8i -: 8]; column c holds bytes 4c..4c+3.
    function automatic logic [BLOCK_W-1:0] enc_round(
        input logic [BLOCK_W-1:0] st,
        input logic [BLOCK_W-1:0] rk,
        input logic               mix_en
    );
        logic [7:0] sb [16];
        logic [7:0] sr [16];
        logic [7:0] mc [16];
        logic [7:0] a, b, c, d;
        logic [BLOCK_W-1:0] res;
        for (int i = 0; i < 16; i++) begin
            sb[i] = SBOX[st[BLOCK_W-1-8*i -: 8]];
        end
        for (int col = 0; col < 4; col++) begin
            for (int row = 0; row < 4; row++) begin
                sr[4*col+row] = sb[4*((col+row) % 4)+row];
            end
        end
        for (int col = 0; col < 4; col++) begin
            a = sr[4*col];
            b = sr[4*col+1];
            c = sr[4*col+2];
            d = sr[4*col+3];
            mc[4*col]   = gf_double(a) ^ gf_double(b) ^ b ^ c ^ d;
            mc[4*col+1] = a ^ gf_double(b) ^ gf_double(c) ^ c ^ d;
            mc[4*col+2] = a ^ b ^ gf_double(c) ^ gf_double(d) ^ d;
            mc[4*col+3] = gf_double(a) ^ a ^ b ^ c ^ gf_double(d);
        end
        for (int i = 0; i < 16; i++) begin
            res[BLOCK_W-1-8*i -: 8] = (mix_en ? mc[i] : sr[i]) ^ rk[BLOCK_W-1-8*i -: 8];
        end
        return res;
    endfunction

endpackage

### hdl/aes128_block_encrypt.sv
// Top level of the pipelined AES-128 encryption engine with loadable round keys.
//
//  channel | direction | handshake        | payload
//  s_      | in        | s_valid/s_ready  | s_data  (opcode, key_slot, key_word, plain)
//  m_      | out       | m_valid/m_ready  | m_data  (cipher_high, cipher_low)
//
// One encrypt item enters per cycle while the first stage can advance; its result
// is offered on m_ once it has passed eleven registers (key whitening stage, then
// one stage per round). Each stage holds when the stage after it is full and
// stalled, so bubbles fill and nothing is dropped or repeated. A key load is taken
// only once the pipeline holds no item, and writes the key store in that cycle if
// its slot is in range; it gives no result. Reset clears all stage valid bits.
module aes128_block_encrypt (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  aes128_pkg::in_item_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output aes128_pkg::out_item_t m_data
);

    localparam int RC = aes128_pkg::ROUND_COUNT;

    logic [aes128_pkg::WORD_W-1:0]  key_store_reg [aes128_pkg::STORE_DEPTH];
    aes128_pkg::stage_t             stage [RC+1];
    logic [RC:0]                    adv;
    logic                           pipe_empty;
    logic                           is_encrypt;
    logic                           accept;
    logic                           key_write;
    logic                           wht_valid_reg;
    logic [aes128_pkg::BLOCK_W-1:0] wht_data_reg;
    logic [aes128_pkg::BLOCK_W-1:0] wht_data_next;

    // Stage advance chain: a stage moves when it is empty or its successor moves
    always_comb begin
        adv[RC] = !stage[RC].valid || m_ready;
        for (int i = RC - 1; i >= 0; i--) begin
            adv[i] = !stage[i].valid || adv[i+1];
        end
    end

    // Pipeline occupancy
    always_comb begin
        pipe_empty = 1'b1;
        for (int i = 0; i <= RC; i++) begin
            if (stage[i].valid) begin
                pipe_empty = 1'b0;
            end
        end
    end

    // Input handshake: loads wait for an empty pipeline
    assign is_encrypt = (s_data.opcode == aes128_pkg::OP_ENCRYPT);
    assign s_ready    = is_encrypt ? adv[0] : pipe_empty;
    assign accept     = s_valid && s_ready;
    assign key_write  = accept && !is_encrypt &&
                        (s_data.key_slot < aes128_pkg::STORE_DEPTH_SLOT);

    // Round-key store
    always_ff @(posedge aclk) begin
        if (key_write) begin
            key_store_reg[s_data.key_slot] <= s_data.key_word;
        end
    end

    // Initial AddRoundKey stage
    assign wht_data_next = {s_data.plain_high, s_data.plain_low} ^
                           {key_store_reg[0], key_store_reg[1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wht_valid_reg <= 1'b0;
        end else if (adv[0]) begin
            wht_valid_reg <= accept && is_encrypt;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            wht_data_reg <= wht_data_next;
        end
    end

    assign stage[0].valid = wht_valid_reg;
    assign stage[0].data  = wht_data_reg;

    // Round stages; the last one skips MixColumns
    for (genvar r = 1; r <= RC; r++) begin : g_round
        aes128_round u_round (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (adv[r]),
            .mix_en    (r != RC),
            .prev      (stage[r-1]),
            .key_in    ({key_store_reg[2*r], key_store_reg[2*r+1]}),
            .cur       (stage[r])
        );
    end

    // Result channel
    assign m_valid            = stage[RC].valid;
    assign m_data.cipher_high = stage[RC].data[aes128_pkg::BLOCK_W-1:aes128_pkg::WORD_W];
    assign m_data.cipher_low  = stage[RC].data[aes128_pkg::WORD_W-1:0];

endmodule

### hdl/aes128_round.sv
// One registered cipher round stage of the AES-128 pipeline.
module aes128_round (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                advance,
    input  logic                                mix_en,
    input  aes128_pkg::stage_t                  prev,
    input  logic [aes128_pkg::BLOCK_W-1:0]      key_in,
    output aes128_pkg::stage_t                  cur
);

    logic                           valid_reg;
    logic [aes128_pkg::BLOCK_W-1:0] data_reg;
    logic [aes128_pkg::BLOCK_W-1:0] data_next;

    // Round logic
    assign data_next = aes128_pkg::enc_round(prev.data, key_in, mix_en);

    // Stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= prev.valid;
        end
    end

    // Stage state, no reset
    always_ff @(posedge aclk) begin
        if (advance) begin
            data_reg <= data_next;
        end
    end

    assign cur.valid = valid_reg;
    assign cur.data  = data_reg;

endmodule

### verif/aes128_cipher_checker.sv
// Channel monitor for the AES-128 engine: predicts each ciphertext and compares results.
module aes128_cipher_checker
    import aes128_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_item_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_item_t m_data,
    output int        fail_count,
    output int        pending
);

    logic [WORD_W-1:0]  key_sched [STORE_DEPTH];
    logic [7:0]         sbox_lut [256];
    logic [BLOCK_W-1:0] cipher_due_q [$];
    int                 mismatches = 0;

    assign fail_count = mismatches;

    // GF(2^8) helpers
    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = '0;
        x   = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc ^= x;
            x = xtime(x);
        end
        return acc;
    endfunction

    // S-box built from scratch: multiplicative inverse, then the affine map
    initial begin
        logic [7:0] inv;
        for (int v = 0; v < 256; v++) begin
            inv = 8'h01;
            for (int k = 0; k < 254; k++) inv = gf_mul(inv, v[7:0]);
            sbox_lut[v] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                        ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
        end
    end

    // Full cipher on one block with the current key schedule
    function automatic logic [BLOCK_W-1:0] encrypt_block(input logic [BLOCK_W-1:0] pt);
        logic [7:0]         st [16];
        logic [7:0]         sh [16];
        logic [BLOCK_W-1:0] rk;
        logic [BLOCK_W-1:0] ct;
        logic [7:0]         a, b, c, d;
        for (int i = 0; i < 16; i++) st[i] = pt[BLOCK_W-1-8*i -: 8];
        rk = {key_sched[0], key_sched[1]};
        for (int i = 0; i < 16; i++) st[i] ^= rk[BLOCK_W-1-8*i -: 8];
        for (int r = 1; r <= ROUND_COUNT; r++) begin
            for (int i = 0; i < 16; i++) st[i] = sbox_lut[st[i]];
            // row r of column c comes from column c+r
            for (int col = 0; col < 4; col++)
                for (int row = 0; row < 4; row++)
                    sh[4*col+row] = st[4*((col+row)%4)+row];
            st = sh;
            if (r < ROUND_COUNT) begin
                for (int col = 0; col < 4; col++) begin
                    a = sh[4*col];
                    b = sh[4*col+1];
                    c = sh[4*col+2];
                    d = sh[4*col+3];
                    st[4*col]   = xtime(a) ^ xtime(b) ^ b ^ c ^ d;
                    st[4*col+1] = a ^ xtime(b) ^ xtime(c) ^ c ^ d;
                    st[4*col+2] = a ^ b ^ xtime(c) ^ xtime(d) ^ d;
                    st[4*col+3] = xtime(a) ^ a ^ b ^ c ^ xtime(d);
                end
            end
            rk = {key_sched[2*r], key_sched[2*r+1]};
            for (int i = 0; i < 16; i++) st[i] ^= rk[BLOCK_W-1-8*i -: 8];
        end
        for (int i = 0; i < 16; i++) ct[BLOCK_W-1-8*i -: 8] = st[i];
        return ct;
    endfunction

    // One line per mismatch
    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Results are checked first, then the accepted item updates the prediction
    always @(posedge aclk) begin
        logic [BLOCK_W-1:0] want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (cipher_due_q.size() == 0) begin
                    report_mismatch("result item with no ciphertext expected");
                end else begin
                    want = cipher_due_q.pop_front();
                    if (m_data.cipher_high !== want[BLOCK_W-1 -: WORD_W])
                        report_mismatch($sformatf("cipher_high got %h want %h",
                                        m_data.cipher_high, want[BLOCK_W-1 -: WORD_W]));
                    if (m_data.cipher_low !== want[WORD_W-1:0])
                        report_mismatch($sformatf("cipher_low got %h want %h",
                                        m_data.cipher_low, want[WORD_W-1:0]));
                end
            end
            if (s_valid && s_ready) begin
                if (s_data.opcode == OP_ENCRYPT) begin
                    cipher_due_q.push_back(encrypt_block({s_data.plain_high,
                                                          s_data.plain_low}));
                end else if (s_data.key_slot < STORE_DEPTH_SLOT) begin
                    key_sched[s_data.key_slot] = s_data.key_word;
                end
            end
        end
        pending <= cipher_due_q.size();
    end

endmodule

### verif/testbench.sv
// Top of the AES-128 engine testbench: clock, reset, stimulus and verdict.
module testbench;
    import aes128_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_ITEMS = 500;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    int fail_count;
    int pending;
    int cycles    = 0;
    int idle_pct  = 0;
    int stall_pct = 0;

    aes128_block_encrypt u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    aes128_cipher_checker u_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 12-unit clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Mostly random, sometimes all zeros or all ones
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(19))
            0:       return '0;
            1:       return '1;
            default: return rand_word();
        endcase
    endfunction

    // Offer one item after a random gap and hold it until taken
    task automatic send_item(input in_item_t it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Unused fields carry random content too
    task automatic load_key(input logic [SLOT_W-1:0] slot, input logic [WORD_W-1:0] word);
        in_item_t it;
        it.opcode     = OP_LOAD_KEY;
        it.key_slot   = slot;
        it.key_word   = word;
        it.plain_high = rand_word();
        it.plain_low  = rand_word();
        send_item(it);
    endtask

    task automatic encrypt(input logic [WORD_W-1:0] hi, input logic [WORD_W-1:0] lo);
        in_item_t it;
        it.opcode     = OP_ENCRYPT;
        it.key_slot   = SLOT_W'($urandom);
        it.key_word   = rand_word();
        it.plain_high = hi;
        it.plain_low  = lo;
        send_item(it);
    endtask

    task automatic load_schedule(input logic [WORD_W-1:0] fill, input bit random_fill);
        for (int k = 0; k < STORE_DEPTH; k++)
            load_key(SLOT_W'(k), random_fill ? pick_word() : fill);
    endtask

    initial begin
        int counted;
        int sel;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: whole schedule of ones, then extreme plaintexts
        load_schedule('1, 1'b0);
        encrypt('0, '0);
        encrypt('1, '1);
        encrypt(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
        // out-of-range slots must leave the store alone
        load_key(SLOT_W'(STORE_DEPTH), '0);
        load_key('1, '0);
        encrypt('0, '1);
        // lowest and highest slot rewritten with zeros
        load_key('0, '0);
        load_key(SLOT_W'(STORE_DEPTH - 1), '0);
        encrypt('1, '0);

        // Random phases: receiver stalls, then sender idles, then full rate
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin idle_pct = 35; stall_pct = 83; end
                1:       begin idle_pct = 83; stall_pct = 35; end
                default: begin idle_pct = 0;  stall_pct = 0;  end
            endcase
            load_schedule('0, 1'b1);
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                sel = $urandom_range(99);
                if (sel < 2) begin
                    load_schedule('0, 1'b1);
                    counted += STORE_DEPTH;
                end else if (sel < 12) begin
                    load_key(SLOT_W'($urandom_range(STORE_DEPTH - 1)), pick_word());
                    counted++;
                end else if (sel < 15) begin
                    // ignored by the block, not counted
                    load_key(SLOT_W'($urandom_range(31, STORE_DEPTH)), pick_word());
                end else begin
                    encrypt(pick_word(), pick_word());
                    counted++;
                end
            end
        end
        s_valid <= 1'b0;

        // Drain, then let the pipeline settle
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);

        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/aes128_pkg.sv
hdl/aes128_round.sv
hdl/aes128_block_encrypt.sv
verif/aes128_cipher_checker.sv
verif/testbench.sv
